// ===== rtl/tbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants of the bright-pixel centroid block.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int MAX_FRAME_WIDTH  = 1024;
	localparam int MAX_FRAME_HEIGHT = 1024;
	localparam int FRACTION_BITS    = 8;

	localparam int PIX_W   = 8;
	localparam int COORD_W = 10;
	localparam int COUNT_W = 21;
	localparam int SUM_W   = 30;
	localparam int CENT_W  = 18;

	localparam int LUMA_B     = 1868;
	localparam int LUMA_G     = 9617;
	localparam int LUMA_R     = 4899;
	localparam int LUMA_SHIFT = 14;
	localparam int LUMA_HALF  = 8192;
	localparam int LUMA_W     = LUMA_SHIFT + PIX_W;

	localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(64);

	// (sum << FRACTION_BITS) + count / 2 and count << CENT_W both fit here
	localparam int DIV_W = COUNT_W + CENT_W;
	localparam int STEP_W = $clog2(CENT_W + 1);

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   col_sum;
		logic [SUM_W-1:0]   row_sum;
	} frame_sums_t;

	typedef struct packed {
		logic               not_empty;
		logic [LEVEL_W-1:0] level;
	} queue_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

// ===== rtl/tbc_front.sv =====
// ----------------------------------------------------------------------------
// tbc_front
// Pixel intake: gray conversion, threshold test and frame accumulation.
// ----------------------------------------------------------------------------
module tbc_front
	import tbc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [PIX_W-1:0]    blue,
	input  logic [PIX_W-1:0]    green,
	input  logic [PIX_W-1:0]    red,
	input  logic [COORD_W-1:0]  column,
	input  logic [COORD_W-1:0]  line_index,
	input  logic                frame_end,
	input  logic                threshold_we,
	input  logic [PIX_W-1:0]    threshold_wdata,
	input  queue_status_t       q_status,
	output logic                q_push,
	output frame_sums_t         q_wdata
);

	logic [PIX_W-1:0]   threshold_q;
	logic               accept;
	logic [LUMA_W-1:0]  luma;
	logic               in_frame;
	logic               bright;

	logic               valid_s1;
	logic               bright_s1;
	logic [COORD_W-1:0] col_s1;
	logic [COORD_W-1:0] row_s1;
	logic               last_s1;

	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   col_sum_q;
	logic [SUM_W-1:0]   row_sum_q;

	logic [COUNT_W:0]   count_add;
	logic [SUM_W:0]     col_add;
	logic [SUM_W:0]     row_add;
	logic [COUNT_W-1:0] count_nxt;
	logic [SUM_W-1:0]   col_nxt;
	logic [SUM_W-1:0]   row_nxt;
	logic [LEVEL_W:0]   committed;

	assign committed = (LEVEL_W+1)'(q_status.level) + (LEVEL_W+1)'(valid_s1 && last_s1);
	assign full      = committed >= (LEVEL_W+1)'(FIFO_DEPTH);
	assign accept    = push && !full;

	assign luma = LUMA_W'(blue) * LUMA_W'(LUMA_B)
	            + LUMA_W'(green) * LUMA_W'(LUMA_G)
	            + LUMA_W'(red) * LUMA_W'(LUMA_R)
	            + LUMA_W'(LUMA_HALF);
	assign in_frame = (32'(column) < MAX_FRAME_WIDTH) && (32'(line_index) < MAX_FRAME_HEIGHT);
	assign bright   = in_frame && (luma[LUMA_SHIFT +: PIX_W] > threshold_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (threshold_we) begin
			threshold_q <= threshold_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bright_s1 <= bright;
			col_s1    <= column;
			row_s1    <= line_index;
			last_s1   <= frame_end;
		end
	end

	assign count_add = (COUNT_W+1)'(count_q) + (COUNT_W+1)'(bright_s1);
	assign col_add   = (SUM_W+1)'(col_sum_q) + (bright_s1 ? (SUM_W+1)'(col_s1) : '0);
	assign row_add   = (SUM_W+1)'(row_sum_q) + (bright_s1 ? (SUM_W+1)'(row_s1) : '0);
	assign count_nxt = count_add[COUNT_W] ? '1 : count_add[COUNT_W-1:0];
	assign col_nxt   = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
	assign row_nxt   = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			col_sum_q <= '0;
			row_sum_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				count_q   <= '0;
				col_sum_q <= '0;
				row_sum_q <= '0;
			end else begin
				count_q   <= count_nxt;
				col_sum_q <= col_nxt;
				row_sum_q <= row_nxt;
			end
		end
	end

	assign q_push          = valid_s1 && last_s1;
	assign q_wdata.count   = count_nxt;
	assign q_wdata.col_sum = col_nxt;
	assign q_wdata.row_sum = row_nxt;

endmodule

// ===== rtl/tbc_queue.sv =====
// ----------------------------------------------------------------------------
// tbc_queue
// Short queue of frame totals between intake and division.
// ----------------------------------------------------------------------------
module tbc_queue
	import tbc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  frame_sums_t   wdata,
	input  logic          pop,
	output frame_sums_t   rdata,
	output queue_status_t status
);

	frame_sums_t        entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;
	logic               do_pop;

	assign do_pop = pop && (level_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				level_q <= level_q + LEVEL_W'(1);
			end else if (do_pop && !push) begin
				level_q <= level_q - LEVEL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata            = entry_q[rd_ptr_q];
	assign status.not_empty = level_q != '0;
	assign status.level     = level_q;

endmodule

// ===== rtl/tbc_back.sv =====
// ----------------------------------------------------------------------------
// tbc_back
// Bit-serial division of frame totals into centroids, with result register.
// ----------------------------------------------------------------------------
module tbc_back
	import tbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  frame_sums_t        q_rdata,
	input  queue_status_t      q_status,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic [CENT_W-1:0]  centroid_x,
	output logic [CENT_W-1:0]  centroid_y,
	output logic               detected
);

	back_state_t        state_q;
	back_state_t        state_d;
	logic               load_en;
	logic               step_en;
	logic               out_load;
	logic               out_valid_q;
	logic               last_step;

	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] rem_x_q;
	logic [COUNT_W-1:0] rem_y_q;
	logic [CENT_W-1:0]  quo_x_q;
	logic [CENT_W-1:0]  quo_y_q;
	logic               ovf_x_q;
	logic               ovf_y_q;

	logic [DIV_W-1:0]   dvd_x;
	logic [DIV_W-1:0]   dvd_y;
	logic [DIV_W-1:0]   dvs_top;
	logic [COUNT_W:0]   trial_x;
	logic [COUNT_W:0]   trial_y;
	logic               ge_x;
	logic               ge_y;

	assign last_step = step_q == STEP_W'(CENT_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		load_en  = 1'b0;
		step_en  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_status.not_empty) begin
					load_en = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				step_en = 1'b1;
				if (last_step) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign q_pop = load_en;

	assign dvd_x   = (DIV_W'(q_rdata.col_sum) << FRACTION_BITS) + DIV_W'(q_rdata.count >> 1);
	assign dvd_y   = (DIV_W'(q_rdata.row_sum) << FRACTION_BITS) + DIV_W'(q_rdata.count >> 1);
	assign dvs_top = DIV_W'(q_rdata.count) << CENT_W;

	assign trial_x = {rem_x_q, quo_x_q[CENT_W-1]};
	assign trial_y = {rem_y_q, quo_y_q[CENT_W-1]};
	assign ge_x    = trial_x >= (COUNT_W+1)'(count_q);
	assign ge_y    = trial_y >= (COUNT_W+1)'(count_q);

	always_ff @(posedge clk) begin
		if (load_en) begin
			count_q <= q_rdata.count;
			ovf_x_q <= dvd_x >= dvs_top;
			ovf_y_q <= dvd_y >= dvs_top;
			rem_x_q <= dvd_x[CENT_W +: COUNT_W];
			rem_y_q <= dvd_y[CENT_W +: COUNT_W];
			quo_x_q <= dvd_x[CENT_W-1:0];
			quo_y_q <= dvd_y[CENT_W-1:0];
		end else if (step_en) begin
			rem_x_q <= ge_x ? COUNT_W'(trial_x - (COUNT_W+1)'(count_q)) : trial_x[COUNT_W-1:0];
			rem_y_q <= ge_y ? COUNT_W'(trial_y - (COUNT_W+1)'(count_q)) : trial_y[COUNT_W-1:0];
			quo_x_q <= {quo_x_q[CENT_W-2:0], ge_x};
			quo_y_q <= {quo_y_q[CENT_W-2:0], ge_y};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (load_en) begin
			step_q <= '0;
		end else if (step_en) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (count_q == '0) begin
				centroid_x <= '0;
				centroid_y <= '0;
				detected   <= 1'b0;
			end else begin
				centroid_x <= ovf_x_q ? '1 : quo_x_q;
				centroid_y <= ovf_y_q ? '1 : quo_y_q;
				detected   <= 1'b1;
			end
		end
	end

	assign empty = !out_valid_q;

endmodule

// ===== rtl/threshold_blob_centroid.sv =====
// ----------------------------------------------------------------------------
// threshold_blob_centroid
// Centroid of the bright pixels of a streamed BGR frame.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while full is low. A pixel counts as bright when
// its rounded BT.601 gray level is strictly above the threshold register
// (reset 64). On the pixel marked frame_end one result is queued: the mean
// column and row in unsigned fixed point with 8 fraction bits, or zeros with
// detected low when no pixel was bright. Frame totals pass through a
// two-entry queue to a bit-serial divider that takes each frame through one
// load, 18 quotient steps and one output write, and takes no new frame until
// the write is done. full rises only while two frames' totals are queued for
// the divider, counting one still on its way in.
// ----------------------------------------------------------------------------
module threshold_blob_centroid
	import tbc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [PIX_W-1:0]   blue,
	input  logic [PIX_W-1:0]   green,
	input  logic [PIX_W-1:0]   red,
	input  logic [COORD_W-1:0] column,
	input  logic [COORD_W-1:0] line_index,
	input  logic               frame_end,
	output logic               empty,
	input  logic               pop,
	output logic [CENT_W-1:0]  centroid_x,
	output logic [CENT_W-1:0]  centroid_y,
	output logic               detected,
	input  logic               threshold_we,
	input  logic [PIX_W-1:0]   threshold_wdata
);

	queue_status_t q_status;
	logic          q_push;
	logic          q_pop;
	frame_sums_t   q_wdata;
	frame_sums_t   q_rdata;

	tbc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.blue            (blue),
		.green           (green),
		.red             (red),
		.column          (column),
		.line_index      (line_index),
		.frame_end       (frame_end),
		.threshold_we    (threshold_we),
		.threshold_wdata (threshold_wdata),
		.q_status        (q_status),
		.q_push          (q_push),
		.q_wdata         (q_wdata)
	);

	tbc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.status (q_status)
	);

	tbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_rdata    (q_rdata),
		.q_status   (q_status),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.centroid_x (centroid_x),
		.centroid_y (centroid_y),
		.detected   (detected)
	);

endmodule

// ===== tb/tb_threshold_blob_centroid.sv =====
// ----------------------------------------------------------------------------
// tb_threshold_blob_centroid
// Self-checking bench for the bright-pixel centroid block.
// ----------------------------------------------------------------------------
// Streams BGR pixels through the push/full side and collects frame results
// through the empty/pop side. A behavioral tracker of the gray-level
// threshold and the frame sums predicts each result not set by the directed
// table, and every transfer on the result side is compared field by field
// with the oldest expected result. A short directed table comes first, then
// random frames under several threshold settings, including both extremes.
// The sender idles in bursts, the receiver stalls on its own pattern, and once
// it holds off long enough for the block to back up into its input.
// ----------------------------------------------------------------------------
module tb_threshold_blob_centroid
	import tbc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CLK_HALF      = 10;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          HOLD_CYCLES   = 500;
	localparam int          NUM_PHASES    = 8;
	localparam int          PHASE_ITEMS   = 120;
	localparam int          PRESSURE_PH   = 2;
	localparam int          MAX_PRINTS    = 60;
	localparam int unsigned CYCLE_LIMIT   = 300000;

	localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_W) - 64'd1;
	localparam longint unsigned SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
	localparam longint unsigned CENT_LIMIT  = (64'd1 << CENT_W) - 64'd1;

	typedef struct {
		logic [PIX_W-1:0]   blue;
		logic [PIX_W-1:0]   green;
		logic [PIX_W-1:0]   red;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] line_index;
		logic               frame_end;
	} pixel_t;

	typedef struct {
		logic [CENT_W-1:0] cx;
		logic [CENT_W-1:0] cy;
		logic              det;
	} centroid_t;

	typedef struct {
		pixel_t    pix;
		bit        typed;
		centroid_t want;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [PIX_W-1:0]   blue = '0;
	logic [PIX_W-1:0]   green = '0;
	logic [PIX_W-1:0]   red = '0;
	logic [COORD_W-1:0] column = '0;
	logic [COORD_W-1:0] line_index = '0;
	logic               frame_end = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic [CENT_W-1:0]  centroid_x;
	logic [CENT_W-1:0]  centroid_y;
	logic               detected;
	logic               threshold_we = 1'b0;
	logic [PIX_W-1:0]   threshold_wdata = '0;

	threshold_blob_centroid uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.blue            (blue),
		.green           (green),
		.red             (red),
		.column          (column),
		.line_index      (line_index),
		.frame_end       (frame_end),
		.empty           (empty),
		.pop             (pop),
		.centroid_x      (centroid_x),
		.centroid_y      (centroid_y),
		.detected        (detected),
		.threshold_we    (threshold_we),
		.threshold_wdata (threshold_wdata)
	);

	// tracker state
	logic [PIX_W-1:0] thr_model;
	longint unsigned  acc_count;
	longint unsigned  acc_col;
	longint unsigned  acc_row;

	centroid_t   pending_centroids[$];
	dir_row_t    dir_rows[$];
	int unsigned mismatch_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned results_checked = 0;
	int unsigned thr_writes = 0;
	int unsigned cycle_count = 0;
	int unsigned input_stalls = 0;
	int unsigned burst_left = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned rx_hold_left = 0;
	int unsigned rx_run_left = 0;
	bit          rx_run_pop = 1'b0;
	centroid_t   rx_want;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
				cycle_count);
	endtask

	function automatic longint unsigned fixed_mean(input longint unsigned sum,
			input longint unsigned count);
		longint unsigned q;
		q = ((sum << FRACTION_BITS) + (count >> 1)) / count;
		return (q > CENT_LIMIT) ? CENT_LIMIT : q;
	endfunction

	task automatic predict_pixel(input pixel_t p, output bit has_res, output centroid_t res);
		longint unsigned gray;
		bit              in_frame;
		gray = (longint'(LUMA_B) * p.blue + longint'(LUMA_G) * p.green
			+ longint'(LUMA_R) * p.red + LUMA_HALF) >> LUMA_SHIFT;
		in_frame = (p.column < MAX_FRAME_WIDTH) && (p.line_index < MAX_FRAME_HEIGHT);
		if (in_frame && gray > thr_model) begin
			acc_count = (acc_count + 1 > COUNT_LIMIT) ? COUNT_LIMIT : acc_count + 1;
			acc_col = (acc_col + p.column > SUM_LIMIT) ? SUM_LIMIT : acc_col + p.column;
			acc_row = (acc_row + p.line_index > SUM_LIMIT) ? SUM_LIMIT
				: acc_row + p.line_index;
		end
		has_res = p.frame_end;
		res.cx = '0;
		res.cy = '0;
		res.det = 1'b0;
		if (p.frame_end) begin
			if (acc_count != 0) begin
				res.cx = CENT_W'(fixed_mean(acc_col, acc_count));
				res.cy = CENT_W'(fixed_mean(acc_row, acc_count));
				res.det = 1'b1;
			end
			acc_count = 0;
			acc_col = 0;
			acc_row = 0;
		end
	endtask

	// Called just after a rising edge; returns at the edge of the transfer, or at the end of the idle gap after it.
	task automatic offer_pixel(input pixel_t p, input bit typed, input centroid_t want);
		bit          has_res;
		centroid_t   res;
		int unsigned gap;
		push <= 1'b1;
		blue <= p.blue;
		green <= p.green;
		red <= p.red;
		column <= p.column;
		line_index <= p.line_index;
		frame_end <= p.frame_end;
		@(posedge clk);
		while (full !== 1'b0)
			@(posedge clk);
		predict_pixel(p, has_res, res);
		pixels_sent++;
		if (has_res)
			pending_centroids.push_back(typed ? want : res);
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic settle_block();
		push <= 1'b0;
		while (pending_centroids.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [PIX_W-1:0] value);
		threshold_we <= 1'b1;
		threshold_wdata <= value;
		@(posedge clk);
		threshold_we <= 1'b0;
		thr_model = value;
		thr_writes++;
	endtask

	task automatic add_row(input int b, input int g, input int r, input int col,
			input int row, input bit last, input bit typed, input int cx,
			input int cy, input bit det);
		dir_row_t d;
		d.pix.blue = PIX_W'(b);
		d.pix.green = PIX_W'(g);
		d.pix.red = PIX_W'(r);
		d.pix.column = COORD_W'(col);
		d.pix.line_index = COORD_W'(row);
		d.pix.frame_end = last;
		d.typed = typed;
		d.want.cx = CENT_W'(cx);
		d.want.cy = CENT_W'(cy);
		d.want.det = det;
		dir_rows.push_back(d);
	endtask

	function automatic pixel_t make_pixel(input int thr, input bit last);
		pixel_t p;
		int     v;
		p.blue = '0;
		p.green = '0;
		p.red = '0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				p.blue = PIX_W'($urandom);
				p.green = PIX_W'($urandom);
				p.red = PIX_W'($urandom);
			end
			4, 5, 6: begin
				// equal channels give a gray level equal to the channel value
				v = thr + int'($urandom_range(0, 4)) - 2;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				p.blue = PIX_W'(v);
				p.green = PIX_W'(v);
				p.red = PIX_W'(v);
			end
			7: begin
				p.blue = '1;
				p.green = '1;
				p.red = '1;
			end
			8: ;
			default: begin
				case ($urandom_range(0, 2))
					0: p.blue = PIX_W'($urandom);
					1: p.green = PIX_W'($urandom);
					default: p.red = PIX_W'($urandom);
				endcase
			end
		endcase
		if ($urandom_range(0, 9) < 3) begin
			p.column = COORD_W'($urandom_range(0, 15));
			p.line_index = COORD_W'($urandom_range(0, 15));
		end else begin
			p.column = COORD_W'($urandom);
			p.line_index = COORD_W'($urandom);
		end
		p.frame_end = last;
		return p;
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (push && full)
			input_stalls++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
				pending_centroids.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && empty === 1'b0) begin
				if (pending_centroids.size() == 0) begin
					report_mismatch("result transfer with no frame pending", detected, 0);
				end else begin
					rx_want = pending_centroids.pop_front();
					results_checked++;
					if (centroid_x !== rx_want.cx)
						report_mismatch("centroid_x", centroid_x, rx_want.cx);
					if (centroid_y !== rx_want.cy)
						report_mismatch("centroid_y", centroid_y, rx_want.cy);
					if (detected !== rx_want.det)
						report_mismatch("detected", detected, rx_want.det);
				end
			end
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				rx_hold_left = HOLD_CYCLES;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				pop <= 1'b0;
			end else begin
				if (rx_run_left == 0) begin
					rx_run_pop = ($urandom_range(0, 9) < 7);
					rx_run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
				end
				rx_run_left--;
				pop <= rx_run_pop;
			end
		end
	end

	initial begin
		int          ph;
		int unsigned phase_start;
		int unsigned frame_len;
		int          thr_now;
		centroid_t   no_want;
		no_want.cx = '0;
		no_want.cy = '0;
		no_want.det = 1'b0;
		thr_model = THRESHOLD_RESET;
		acc_count = 0;
		acc_col = 0;
		acc_row = 0;

		// threshold at reset value: gray of equal channels is the channel value
		add_row(0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
		add_row(255, 255, 255, 1023, 1023, 1, 1, 261888, 261888, 1);
		add_row(255, 255, 255, 0, 0, 1, 1, 0, 0, 1);
		add_row(64, 64, 64, 5, 5, 1, 1, 0, 0, 0);
		add_row(65, 65, 65, 5, 7, 1, 1, 1280, 1792, 1);
		add_row(0, 255, 0, 1, 2, 0, 0, 0, 0, 0);
		add_row(0, 0, 255, 2, 3, 0, 0, 0, 0, 0);
		add_row(255, 0, 0, 1000, 1000, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 3, 0, 1, 0, 0, 0, 0);
		add_row(200, 200, 200, 0, 0, 0, 0, 0, 0, 0);
		add_row(200, 200, 200, 0, 1, 0, 0, 0, 0, 0);
		add_row(200, 200, 200, 1, 1, 1, 0, 0, 0, 0);
		add_row(255, 255, 255, 682, 341, 0, 0, 0, 0, 0);
		add_row(255, 255, 255, 341, 682, 1, 0, 0, 0, 0);
		add_row(128, 128, 128, 1023, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 1023, 1023, 0, 0, 0, 0, 0);
		add_row(255, 255, 255, 0, 1023, 1, 0, 0, 0, 0);
		add_row(0, 0, 0, 512, 512, 1, 1, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i])
			offer_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			settle_block();
			case (ph)
				0: thr_now = 0;
				1: thr_now = 255;
				2: thr_now = 1;
				3: thr_now = 254;
				default: thr_now = $urandom_range(0, 255);
			endcase
			write_threshold(PIX_W'(thr_now));
			phase_start = pixels_sent;
			if (ph == PRESSURE_PH) begin
				// stall the result side while single-pixel frames keep coming
				hold_requests <= hold_requests + 1;
				repeat (40)
					offer_pixel(make_pixel(thr_now, 1'b1), 1'b0, no_want);
			end
			while (pixels_sent - phase_start < PHASE_ITEMS) begin
				frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
					: $urandom_range(1, 6);
				for (int k = 1; k <= frame_len; k++)
					offer_pixel(make_pixel(thr_now, k == frame_len), 1'b0, no_want);
			end
		end
		settle_block();

		$display("Covered %0d pixels and %0d frame results over %0d threshold settings",
			pixels_sent, results_checked, thr_writes + 1);
		$display("Input side was held off by full for %0d cycles", input_stalls);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
